FILE: rtl/sliding_window_receiver_unit_defines.svh
// assertion macros shared by the receiver rtl
`ifndef SLIDING_WINDOW_RECEIVER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_RECEIVER_UNIT_DEFINES_SVH

// property that must hold in the same cycle
`define SWR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/swr_pkg.sv
// types and constants of the sliding window receiver
package swr_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SEQ_W        = 31;
    localparam int CFG_W        = 6;
    localparam int CNT_W        = 6;
    localparam int SLOT_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WINDOW_RESET = 30;

    typedef enum logic {
        S_IDLE,
        S_SHIFT
    } t_state;

    // command broadcast to every slot cell
    typedef struct packed {
        logic              mark;
        logic              shift;
        logic [SLOT_W-1:0] slot;
    } t_cell_ctrl;

endpackage

FILE: rtl/swr_cell.sv
// one slot of the seen bitmap
module swr_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  swr_pkg::t_cell_ctrl       i_ctrl,
    input  logic [swr_pkg::SLOT_W-1:0] i_slot_id,
    input  logic                      i_from_right,
    output logic                      o_bit
);
    import swr_pkg::*;

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.shift) begin
            n_bit = i_from_right;
        end else if (i_ctrl.mark && (i_ctrl.slot == i_slot_id)) begin
            n_bit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

FILE: rtl/swr_chain.sv
// row of slot cells, each shifting toward slot zero
module swr_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swr_pkg::t_cell_ctrl           i_ctrl,
    output logic [swr_pkg::MAX_WINDOW-1:0] o_bits
);
    import swr_pkg::*;

    logic [MAX_WINDOW-1:0] w_bits;
    logic [MAX_WINDOW-1:0] w_from_right;

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            if (g == MAX_WINDOW - 1) begin : g_last
                assign w_from_right[g] = 1'b0;
            end else begin : g_mid
                assign w_from_right[g] = w_bits[g+1];
            end
            swr_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (i_ctrl),
                .i_slot_id   (SLOT_W'(g)),
                .i_from_right(w_from_right[g]),
                .o_bit       (w_bits[g])
            );
        end
    endgenerate

    assign o_bits = w_bits;

endmodule

FILE: rtl/sliding_window_receiver_unit.sv
// top level of the sliding window receiver
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_seq_num
//  out     | output    | o_out_valid / i_out_stall | o_cumulative_ack, o_newly_delivered
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_window_size
//
// an in-window packet marks its slot in the cell row, then the row shifts toward the front
// once per delivered slot, then the result is loaded.
// a packet outside the window is accepted and gives no result.
// the result register lets the next packet in while the last result is stalled;
// a stalled result delays only the load of the following one.
// synchronous active-low reset: window 30, bitmap clear, next expected and last ack at 1, output ack not reset.
module sliding_window_receiver_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [swr_pkg::SEQ_W-1:0] i_seq_num,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [swr_pkg::SEQ_W-1:0] o_cumulative_ack,
    output logic [swr_pkg::CNT_W-1:0] o_newly_delivered,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [swr_pkg::CFG_W-1:0] i_cfg_window_size
);
    import swr_pkg::*;
    `include "sliding_window_receiver_unit_defines.svh"

    t_state            r_state;
    t_state            n_state;
    logic [CFG_W-1:0]  r_window;
    logic [SEQ_W-1:0]  r_next;
    logic [SEQ_W-1:0]  r_last;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [SEQ_W-1:0]  r_out_ack;
    logic [CNT_W-1:0]  r_out_cnt;

    logic [SEQ_W-1:0]      w_offset;
    logic                  w_in_win;
    logic                  w_accept;
    logic                  w_front;
    logic                  w_shift;
    logic                  w_load;
    logic [MAX_WINDOW-1:0] w_bits;
    t_cell_ctrl            w_ctrl;

    assign o_cfg_ready = 1'b1;

    // window test, modulo 2^31
    assign w_offset = i_seq_num - r_next;
    assign w_in_win = (w_offset < {{(SEQ_W-CFG_W){1'b0}}, r_window})
                   && (w_offset < SEQ_W'(MAX_WINDOW));
    assign w_accept = i_in_valid && !o_in_stall;

    swr_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .o_bits (w_bits)
    );

    assign w_front = w_bits[0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_in_win) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_stall  = 1'b1;
        w_shift     = 1'b0;
        w_load      = 1'b0;
        w_ctrl.mark = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                // input is never stalled while idle
                w_ctrl.mark = i_in_valid && w_in_win;
            end
            S_SHIFT: begin
                w_shift = w_front;
                w_load  = !w_front && (!r_out_valid || !i_out_stall);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        w_ctrl.shift = w_shift;
        w_ctrl.slot  = w_offset[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= CFG_W'(WINDOW_RESET);
            r_next      <= SEQ_W'(1);
            r_last      <= SEQ_W'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_window_size;
            end
            if (w_accept) begin
                r_count <= '0;
            end else if (w_shift) begin
                // saturating delivery count
                r_count <= (r_count == '1) ? r_count : r_count + CNT_W'(1);
            end
            if (w_shift) begin
                r_next <= r_next + SEQ_W'(1);
                r_last <= r_next;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ack <= r_last;
            r_out_cnt <= r_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cumulative_ack  = r_out_ack;
    assign o_newly_delivered = r_out_cnt;

    `SWR_ASSERT_NEXT(a_mark_sets_slot, i_clk, i_rst_n, w_accept && w_in_win, w_bits != '0,
        "in-window packet left the bitmap empty")
    `SWR_ASSERT(a_idle_front_clear, i_clk, i_rst_n, (r_state != S_IDLE) || !w_front,
        "front slot marked while idle")
    `SWR_ASSERT_NEXT(a_shift_advances, i_clk, i_rst_n, w_shift,
        r_next == $past(r_next) + SEQ_W'(1) && r_last == $past(r_next),
        "shift did not advance next expected by one")
    `SWR_ASSERT(a_count_bound, i_clk, i_rst_n,
        {1'b0, r_count} <= (CNT_W+1)'(MAX_WINDOW),
        "delivery count beyond window capacity")

endmodule
